FILE: rtl/image_tile_grid_generator_macros.svh
// Assertion macros for the image tile grid generator checker.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef IMAGE_TILE_GRID_GENERATOR_MACROS_SVH
`define IMAGE_TILE_GRID_GENERATOR_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ITG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ITG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/itg_pkg.sv
// Shared constants, register indexes and control structs of the tile grid generator.
// No dependencies; the design files and interfaces refer to it by scoped names.
`default_nettype none

package itg_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_TILES_DEF  = 6;
    localparam int COORD_BITS_DEF = 16;

    // Fixed field widths.
    localparam int COUNT_W    = 3;
    localparam int LABEL_W    = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TILES_ACROSS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TILES_DOWN     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_ENABLE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_MODE    = CFG_IDX_W'(3);

    // Register reset values.
    localparam logic [COUNT_W-1:0] TILES_ACROSS_RST   = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] TILES_DOWN_RST     = COUNT_W'(3);
    localparam logic               OVERLAP_ENABLE_RST = 1'b0;
    localparam logic               SQUARE_MODE_RST    = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_axis_y;
        logic build_step;
        logic emit_init;
        logic emit_step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_zero;
        logic div_done;
        logic build_last;
        logic out_free;
        logic emit_last;
    } t_dp_status;

    // A count of zero acts as one, a count above the maximum acts as the maximum.
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c,
                                                       input logic [COUNT_W-1:0] max_c);
        if (c == COUNT_W'(0)) begin
            return COUNT_W'(1);
        end
        if (c > max_c) begin
            return max_c;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/itg_interfaces.sv
// Valid/ready channel interfaces: frame sizes in, rectangles out, register writes.
// Depends on itg_pkg for default and field widths.
`default_nettype none

interface itg_frame_if #(
    parameter int COORD_BITS = itg_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] frame_width;
    logic [COORD_BITS-1:0] frame_height;

    modport source (output valid, output frame_width, output frame_height, input ready);
    modport sink   (input valid, input frame_width, input frame_height, output ready);
endinterface

interface itg_rect_if #(
    parameter int COORD_BITS = itg_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [itg_pkg::LABEL_W-1:0]  tile_label;
    logic signed [COORD_BITS:0]   rect_left;
    logic signed [COORD_BITS:0]   rect_top;
    logic signed [COORD_BITS:0]   rect_right;
    logic signed [COORD_BITS:0]   rect_bottom;
    logic                         shifted_tile;
    logic                         last_rect;

    modport source (output valid, output tile_label, output rect_left, output rect_top,
                    output rect_right, output rect_bottom, output shifted_tile,
                    output last_rect, input ready);
    modport sink   (input valid, input tile_label, input rect_left, input rect_top,
                    input rect_right, input rect_bottom, input shifted_tile,
                    input last_rect, output ready);
endinterface

interface itg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [itg_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [itg_pkg::CFG_DATA_W-1:0] reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/image_tile_grid_generator.sv
// An accepted frame reaches its first rectangle through the serial divider and the table
// build, once per axis. Then one rectangle beat per cycle while the sink is ready; the next
// frame is taken the cycle after the last rectangle enters the output register.
// Empty frames go from the start state straight back to idle, which frees the input.
// Reset (synchronous, active low) loads the register defaults and empties the output.
`default_nettype none

module image_tile_grid_generator #(
    parameter int MAX_TILES_PER_AXIS = itg_pkg::MAX_TILES_DEF,
    parameter int COORD_BITS         = itg_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itg_frame_if.sink   i_frame,
    itg_rect_if.source  o_rect,
    itg_cfg_if.sink     i_cfg
);

    itg_pkg::t_dp_cmd    dp_cmd;
    itg_pkg::t_dp_status dp_status;
    logic                in_ready;
    logic                cfg_ready;
    logic                out_valid;
    logic [itg_pkg::LABEL_W-1:0] out_label;
    logic [COORD_BITS:0] out_left, out_top, out_right, out_bottom;
    logic                out_shifted, out_last;

    // Sequencing.
    itg_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_frame.valid),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Arithmetic, tables and the output register.
    itg_datapath #(
        .MAX_TILES_PER_AXIS (MAX_TILES_PER_AXIS),
        .COORD_BITS         (COORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (i_frame.frame_width),
        .i_frame_height (i_frame.frame_height),
        .i_cfg_valid    (i_cfg.valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (i_cfg.reg_index),
        .i_cfg_data     (i_cfg.reg_data),
        .i_out_ready    (o_rect.ready),
        .o_out_valid    (out_valid),
        .o_tile_label   (out_label),
        .o_rect_left    (out_left),
        .o_rect_top     (out_top),
        .o_rect_right   (out_right),
        .o_rect_bottom  (out_bottom),
        .o_shifted_tile (out_shifted),
        .o_last_rect    (out_last),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status)
    );

    // Channel outputs.
    assign i_frame.ready       = in_ready;
    assign i_cfg.ready         = cfg_ready;
    assign o_rect.valid        = out_valid;
    assign o_rect.tile_label   = out_label;
    assign o_rect.rect_left    = out_left;
    assign o_rect.rect_top     = out_top;
    assign o_rect.rect_right   = out_right;
    assign o_rect.rect_bottom  = out_bottom;
    assign o_rect.shifted_tile = out_shifted;
    assign o_rect.last_rect    = out_last;

endmodule

`default_nettype wire

FILE: rtl/itg_divider.sv
// Bit-serial restoring divider of a frame side by a small tile count.
// Depends on itg_pkg; one quotient bit per cycle.
`default_nettype none

module itg_divider #(
    parameter int NUM_W = itg_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [NUM_W-1:0]            i_dividend,
    input  logic [itg_pkg::COUNT_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [NUM_W-1:0]            o_quotient,
    output logic [itg_pkg::COUNT_W-1:0] o_remainder
);

    localparam int CW     = itg_pkg::COUNT_W;
    localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_quo;
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     r_div;

    logic [CW:0] rem_shift;
    logic        fits;
    logic [CW:0] rem_next;

    // One restoring step: bring down the next dividend bit and try the subtract.
    always_comb begin
        rem_shift = {r_rem, r_quo[NUM_W-1]};
        fits      = rem_shift >= {1'b0, r_div};
        rem_next  = fits ? (rem_shift - {1'b0, r_div}) : rem_shift;
    end

    // Sequencing of the division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(0)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in where the dividend bits shift out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= rem_next[CW-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

FILE: rtl/itg_controller.sv
// Sequencing state machine of the tile grid generator.
// Depends on itg_pkg for the command and status structs.
`default_nettype none

module itg_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  itg_pkg::t_dp_status i_status,
    output itg_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_START   = 3'd1;
    localparam logic [2:0] S_DIV_X   = 3'd2;
    localparam logic [2:0] S_BUILD_X = 3'd3;
    localparam logic [2:0] S_DIV_Y   = 3'd4;
    localparam logic [2:0] S_BUILD_Y = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_status.frame_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.div_start  = 1'b1;
                    o_cmd.div_axis_y = 1'b0;
                    n_state          = S_DIV_X;
                end
            end
            S_DIV_X: begin
                if (i_status.div_done) begin
                    n_state = S_BUILD_X;
                end
            end
            S_BUILD_X: begin
                o_cmd.build_step = 1'b1;
                if (i_status.build_last) begin
                    o_cmd.div_start  = 1'b1;
                    o_cmd.div_axis_y = 1'b1;
                    n_state          = S_DIV_Y;
                end
            end
            S_DIV_Y: begin
                if (i_status.div_done) begin
                    n_state = S_BUILD_Y;
                end
            end
            S_BUILD_Y: begin
                o_cmd.build_step = 1'b1;
                if (i_status.build_last) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/itg_datapath.sv
// Datapath: configuration registers, axis tables, divider and rectangle output register.
// Depends on itg_pkg and instantiates itg_divider.
`default_nettype none

module itg_datapath #(
    parameter int MAX_TILES_PER_AXIS = itg_pkg::MAX_TILES_DEF,
    parameter int COORD_BITS         = itg_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [COORD_BITS-1:0]          i_frame_width,
    input  logic [COORD_BITS-1:0]          i_frame_height,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [itg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [itg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [itg_pkg::LABEL_W-1:0]    o_tile_label,
    output logic [COORD_BITS:0]            o_rect_left,
    output logic [COORD_BITS:0]            o_rect_top,
    output logic [COORD_BITS:0]            o_rect_right,
    output logic [COORD_BITS:0]            o_rect_bottom,
    output logic                           o_shifted_tile,
    output logic                           o_last_rect,
    input  itg_pkg::t_dp_cmd               i_cmd,
    output itg_pkg::t_dp_status            o_status
);

    localparam int CW    = itg_pkg::COUNT_W;
    localparam int LW    = itg_pkg::LABEL_W;
    localparam int CNT_W = $clog2(MAX_TILES_PER_AXIS + 1);
    localparam int IDX_W = (MAX_TILES_PER_AXIS > 1) ? $clog2(MAX_TILES_PER_AXIS) : 1;
    localparam int ACC_W = COORD_BITS + CNT_W;
    localparam int OUT_W = COORD_BITS + 1;
    localparam logic [CW-1:0]    MAX_COUNT = CW'(MAX_TILES_PER_AXIS);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_TILES_PER_AXIS);

    // Configuration registers.
    logic [CW-1:0] r_tiles_across;
    logic [CW-1:0] r_tiles_down;
    logic          r_overlap_enable;
    logic          r_square_mode;

    // Frame captured at accept.
    logic [COORD_BITS-1:0] r_len_x, r_len_y;
    logic [COORD_BITS-1:0] r_num_x, r_num_y;
    logic [CW-1:0]         r_den_x, r_den_y;
    logic                  r_square, r_ovl, r_zero;

    // Division results per axis.
    logic                  r_axis;
    logic [COORD_BITS-1:0] r_q_x, r_q_y;
    logic [CW-1:0]         r_r_x, r_r_y;

    // Table build.
    logic [ACC_W-1:0] r_acc_q;
    logic [CW-1:0]    r_acc_r;
    logic [CNT_W-1:0] r_bi;
    logic [CNT_W-1:0] r_n_x, r_n_y;
    logic [COORD_BITS-1:0] r_start_x [MAX_TILES_PER_AXIS];
    logic [COORD_BITS-1:0] r_start_y [MAX_TILES_PER_AXIS];
    logic [OUT_W-1:0]      r_stop_x  [MAX_TILES_PER_AXIS];
    logic [OUT_W-1:0]      r_stop_y  [MAX_TILES_PER_AXIS];

    // Emission walk and output register.
    logic [IDX_W-1:0] r_ex, r_ey;
    logic             r_phase;
    logic [LW-1:0]    r_label;
    logic             r_out_valid;
    logic [LW-1:0]    r_out_label;
    logic [OUT_W-1:0] r_out_left, r_out_top, r_out_right, r_out_bottom;
    logic             r_out_shifted, r_out_last;

    logic [CW-1:0]         tx, ty;
    logic                  div_done;
    logic [COORD_BITS-1:0] div_q;
    logic [CW-1:0]         div_r;

    logic [COORD_BITS-1:0] b_q, b_len;
    logic [CW-1:0]         b_r, b_den;
    logic                  acc_lt_len, carry, in_range;
    logic [CW:0]           rem_sum, rem_fix;
    logic [ACC_W-1:0]      n_acc_q, acc_m1;
    logic [CNT_W-1:0]      bi_m1;

    logic [OUT_W-1:0] t_x, t_y, ls_x, ls_y, wi_x, hi_y, off_x, off_y;
    logic             shift_any, has_shift;
    logic [CNT_W-1:0] nxm1, nym1, x_lim, y_lim;
    logic             x_at_lim, y_at_lim, x_is_end, y_is_end, phase_end, emit_last;
    logic [OUT_W-1:0] base_left, base_top, base_right, base_bottom;

    // Register writes; the port is always ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles_across   <= itg_pkg::TILES_ACROSS_RST;
            r_tiles_down     <= itg_pkg::TILES_DOWN_RST;
            r_overlap_enable <= itg_pkg::OVERLAP_ENABLE_RST;
            r_square_mode    <= itg_pkg::SQUARE_MODE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                itg_pkg::REG_TILES_ACROSS:   r_tiles_across   <= i_cfg_data;
                itg_pkg::REG_TILES_DOWN:     r_tiles_down     <= i_cfg_data;
                itg_pkg::REG_OVERLAP_ENABLE: r_overlap_enable <= i_cfg_data[0];
                itg_pkg::REG_SQUARE_MODE:    r_square_mode    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Capture the frame and pick the numerator and divisor of each axis.
    assign tx = itg_pkg::clamp_count(r_tiles_across, MAX_COUNT);
    assign ty = itg_pkg::clamp_count(r_tiles_down, MAX_COUNT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len_x  <= i_frame_width;
            r_len_y  <= i_frame_height;
            r_square <= r_square_mode;
            r_ovl    <= r_overlap_enable;
            r_zero   <= (i_frame_width == '0) || (i_frame_height == '0);
            if (!r_square_mode) begin
                r_num_x <= i_frame_width;
                r_den_x <= tx;
                r_num_y <= i_frame_height;
                r_den_y <= ty;
            end else if (i_frame_width > i_frame_height) begin
                r_num_x <= i_frame_width;
                r_den_x <= tx;
                r_num_y <= i_frame_width;
                r_den_y <= tx;
            end else begin
                r_num_x <= i_frame_height;
                r_den_x <= ty;
                r_num_y <= i_frame_height;
                r_den_y <= ty;
            end
        end
    end

    // Shared divider gives the whole and fractional part of the tile size.
    itg_divider #(
        .NUM_W (COORD_BITS)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (i_cmd.div_axis_y ? r_num_y : r_num_x),
        .i_divisor   (i_cmd.div_axis_y ? r_den_y : r_den_x),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_axis <= i_cmd.div_axis_y;
        end
    end

    // Step of the build: the start accumulates the tile size as quotient plus remainder.
    always_comb begin
        b_q        = r_axis ? r_q_y : r_q_x;
        b_r        = r_axis ? r_r_y : r_r_x;
        b_den      = r_axis ? r_den_y : r_den_x;
        b_len      = r_axis ? r_len_y : r_len_x;
        acc_lt_len = r_acc_q < ACC_W'(b_len);
        rem_sum    = {1'b0, r_acc_r} + {1'b0, b_r};
        carry      = rem_sum >= {1'b0, b_den};
        rem_fix    = carry ? (rem_sum - {1'b0, b_den}) : rem_sum;
        n_acc_q    = r_acc_q + ACC_W'(b_q) + ACC_W'(carry);
        acc_m1     = r_acc_q - ACC_W'(1);
        bi_m1      = r_bi - CNT_W'(1);
        in_range   = r_bi < MAX_CNT;
    end

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            if (r_axis) begin
                r_q_y <= div_q;
                r_r_y <= div_r;
                r_n_y <= '0;
            end else begin
                r_q_x <= div_q;
                r_r_x <= div_r;
                r_n_x <= '0;
            end
            r_acc_q <= '0;
            r_acc_r <= '0;
            r_bi    <= '0;
        end else if (i_cmd.build_step) begin
            r_acc_q <= n_acc_q;
            r_acc_r <= rem_fix[CW-1:0];
            r_bi    <= r_bi + CNT_W'(1);
            if (in_range) begin
                if (r_axis) begin
                    r_start_y[r_bi[IDX_W-1:0]] <= r_acc_q[COORD_BITS-1:0];
                    if (acc_lt_len) begin
                        r_n_y <= r_n_y + CNT_W'(1);
                    end
                end else begin
                    r_start_x[r_bi[IDX_W-1:0]] <= r_acc_q[COORD_BITS-1:0];
                    if (acc_lt_len) begin
                        r_n_x <= r_n_x + CNT_W'(1);
                    end
                end
            end
            // The stop of the previous tile is one before this start.
            if (r_bi != '0) begin
                if (r_axis) begin
                    r_stop_y[bi_m1[IDX_W-1:0]] <= acc_m1[OUT_W-1:0];
                end else begin
                    r_stop_x[bi_m1[IDX_W-1:0]] <= acc_m1[OUT_W-1:0];
                end
            end
        end
    end

    // Square mode last start: length minus tile size, truncated toward zero.
    always_comb begin
        t_x  = OUT_W'(r_len_x) - OUT_W'(r_q_x);
        t_y  = OUT_W'(r_len_y) - OUT_W'(r_q_y);
        ls_x = (!t_x[OUT_W-1] && (t_x != '0) && (r_r_x != '0)) ? (t_x - OUT_W'(1)) : t_x;
        ls_y = (!t_y[OUT_W-1] && (t_y != '0) && (r_r_y != '0)) ? (t_y - OUT_W'(1)) : t_y;
        wi_x = OUT_W'(r_q_x >> 1);
        hi_y = OUT_W'(r_q_y >> 1);
        shift_any = (r_q_x[COORD_BITS-1:1] != '0) || (r_q_y[COORD_BITS-1:1] != '0);
        has_shift = r_ovl && shift_any && (r_n_x > CNT_W'(1)) && (r_n_y > CNT_W'(1));
    end

    // Current rectangle of the walk.
    always_comb begin
        nxm1      = r_n_x - CNT_W'(1);
        nym1      = r_n_y - CNT_W'(1);
        x_lim     = r_phase ? (r_n_x - CNT_W'(2)) : nxm1;
        y_lim     = r_phase ? (r_n_y - CNT_W'(2)) : nym1;
        x_at_lim  = CNT_W'(r_ex) == x_lim;
        y_at_lim  = CNT_W'(r_ey) == y_lim;
        x_is_end  = CNT_W'(r_ex) == nxm1;
        y_is_end  = CNT_W'(r_ey) == nym1;
        phase_end = x_at_lim && y_at_lim;
        emit_last = phase_end && (r_phase || !has_shift);

        base_left   = (r_square && x_is_end) ? ls_x : OUT_W'(r_start_x[r_ex]);
        base_top    = (r_square && y_is_end) ? ls_y : OUT_W'(r_start_y[r_ey]);
        base_right  = x_is_end ? (OUT_W'(r_len_x) - OUT_W'(1)) : r_stop_x[r_ex];
        base_bottom = y_is_end ? (OUT_W'(r_len_y) - OUT_W'(1)) : r_stop_y[r_ey];
        off_x       = r_phase ? wi_x : '0;
        off_y       = r_phase ? hi_y : '0;
    end

    // Walk order: x outer, y inner, primary grid then shifted grid.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_init) begin
            r_ex    <= '0;
            r_ey    <= '0;
            r_phase <= 1'b0;
            r_label <= LW'(1);
        end else if (i_cmd.emit_step) begin
            r_label <= r_label + LW'(1);
            if (y_at_lim) begin
                r_ey <= '0;
                if (x_at_lim) begin
                    r_ex    <= '0;
                    r_phase <= 1'b1;
                end else begin
                    r_ex <= r_ex + IDX_W'(1);
                end
            end else begin
                r_ey <= r_ey + IDX_W'(1);
            end
        end
    end

    // Output register: holds the beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_step) begin
            r_out_label   <= r_label;
            r_out_left    <= base_left + off_x;
            r_out_top     <= base_top + off_y;
            r_out_right   <= base_right + off_x;
            r_out_bottom  <= base_bottom + off_y;
            r_out_shifted <= r_phase;
            r_out_last    <= emit_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_tile_label   = r_out_label;
    assign o_rect_left    = r_out_left;
    assign o_rect_top     = r_out_top;
    assign o_rect_right   = r_out_right;
    assign o_rect_bottom  = r_out_bottom;
    assign o_shifted_tile = r_out_shifted;
    assign o_last_rect    = r_out_last;

    // Status towards the controller.
    always_comb begin
        o_status.frame_zero = r_zero;
        o_status.div_done   = div_done;
        o_status.build_last = (r_bi == MAX_CNT);
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.emit_last  = emit_last;
    end

endmodule

`default_nettype wire

FILE: rtl/itg_checker.sv
// Port-level assertions for the tile grid generator, bound to the top level.
// Depends on the channel interfaces and the assertion macro header.
`default_nettype none
`include "image_tile_grid_generator_macros.svh"

module itg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    itg_frame_if.sink  i_frame,
    itg_rect_if.source o_rect
);

    // Reset empties the output register.
    `ITG_ASSERT_ALWAYS(a_reset_empties_out, !i_rst_n |=> !o_rect.valid, "output valid after reset")

    // A stalled rectangle beat keeps its contents.
    `ITG_ASSERT(a_out_hold, o_rect.valid && !o_rect.ready |=> o_rect.valid && $stable(o_rect.tile_label) && $stable(o_rect.rect_left) && $stable(o_rect.rect_bottom) && $stable(o_rect.last_rect), "stalled rectangle changed")

    // No new frame is taken while the current frame still has rectangles to come.
    `ITG_ASSERT(a_no_frame_mid_grid, o_rect.valid && !o_rect.last_rect |-> !i_frame.ready, "frame accepted before the grid was complete")

    // The shifted grid only follows a primary grid of at least two by two tiles.
    `ITG_ASSERT(a_shifted_label, o_rect.valid && o_rect.shifted_tile |-> o_rect.tile_label > 6'd4, "shifted rectangle with too low a label")

endmodule

bind image_tile_grid_generator itg_checker u_itg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_frame (i_frame),
    .o_rect  (o_rect)
);

`default_nettype wire
